/* hw/rtl/usd_pkg.sv */
`default_nettype none

package usd_pkg;

	localparam int BYTE_W = 8;
	localparam int ACC_W  = 32;
	localparam int CP_W   = 21;

	typedef logic [2:0]        trail_cnt_t;
	typedef logic [ACC_W-1:0]  acc_t;
	typedef logic [CP_W-1:0]   cp_t;

	localparam acc_t CP_MAX_LEGAL  = 32'h0010_FFFF;
	localparam acc_t CP_SURR_FIRST = 32'h0000_D800;
	localparam acc_t CP_SURR_LAST  = 32'h0000_DFFF;
	localparam acc_t CP_REPLACE    = 32'h0000_FFFD;

	localparam acc_t OFFSET_1 = 32'h0000_3080;
	localparam acc_t OFFSET_2 = 32'h000E_2080;
	localparam acc_t OFFSET_3 = 32'h03C8_2080;
	localparam acc_t OFFSET_4 = 32'hFA08_2080;
	localparam acc_t OFFSET_5 = 32'h8208_2080;

	// Trailing byte count implied by a lead byte
	function automatic trail_cnt_t trailers_of(input logic [BYTE_W-1:0] b);
		trail_cnt_t n;
		case (b) inside
			[8'h00:8'hBF]: n = 3'd0;
			[8'hC0:8'hDF]: n = 3'd1;
			[8'hE0:8'hEF]: n = 3'd2;
			[8'hF0:8'hF7]: n = 3'd3;
			[8'hF8:8'hFB]: n = 3'd4;
			default:       n = 3'd5;
		endcase
		return n;
	endfunction

	// Offset removed once a sequence of the given length is summed
	function automatic acc_t length_offset(input trail_cnt_t n);
		acc_t off;
		case (n)
			3'd1:    off = OFFSET_1;
			3'd2:    off = OFFSET_2;
			3'd3:    off = OFFSET_3;
			3'd4:    off = OFFSET_4;
			3'd5:    off = OFFSET_5;
			default: off = '0;
		endcase
		return off;
	endfunction

	// Remove offset, replace illegal and surrogate values
	function automatic cp_t finish(input acc_t sum, input trail_cnt_t n);
		acc_t v;
		v = sum - length_offset(n);
		if (v > CP_MAX_LEGAL || (v >= CP_SURR_FIRST && v <= CP_SURR_LAST)) begin
			v = CP_REPLACE;
		end
		return v[CP_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/utf8_stream_decoder.sv */
// Channel  | Handshake                  | Payload
// ---------+----------------------------+--------------------------
// input    | in_valid / in_stall        | byte_in    [7:0]  one byte
// output   | out_valid / out_stall      | code_point [20:0] one code point
//
// One byte is taken every cycle unless in_stall is high; the result of a completed
// sequence appears in the output register in the cycle after its last byte is taken.
// The result is formed by the single accumulate-and-finish step per byte.
// in_stall rises only while a held result is itself stalled downstream.
// Reset clears the sequence counters and the output valid flag.
`default_nettype none

module utf8_stream_decoder (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire  [usd_pkg::BYTE_W-1:0] byte_in,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic [usd_pkg::CP_W-1:0]   code_point
);
	import usd_pkg::*;

	acc_t       acc_q;
	trail_cnt_t rem_q;
	trail_cnt_t trl_q;
	logic       out_valid_q;
	cp_t        cp_q;

	logic       in_acc;
	trail_cnt_t lead_n;
	acc_t       sum;
	acc_t       acc_d;
	trail_cnt_t rem_d;
	trail_cnt_t trl_d;
	logic       res_d;
	cp_t        cp_d;

	// Hold input only while the held result cannot leave
	assign in_stall   = out_valid_q && out_stall;
	assign in_acc     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign code_point = cp_q;

	// Advance the sequence by one byte
	always_comb begin
		lead_n = trailers_of(byte_in);
		sum    = acc_q + {{(ACC_W-BYTE_W){1'b0}}, byte_in};
		acc_d  = acc_q;
		rem_d  = rem_q;
		trl_d  = trl_q;
		res_d  = 1'b0;
		cp_d   = finish(sum, trl_q);
		if (rem_q == 3'd0) begin
			if (lead_n == 3'd0) begin
				res_d = 1'b1;
				cp_d  = finish({{(ACC_W-BYTE_W){1'b0}}, byte_in}, 3'd0);
				acc_d = '0;
			end else begin
				acc_d = {{(ACC_W-BYTE_W-6){1'b0}}, byte_in, 6'd0};
				rem_d = lead_n;
				trl_d = lead_n;
			end
		end else begin
			rem_d = rem_q - 3'd1;
			if (rem_q == 3'd1) begin
				res_d = 1'b1;
				acc_d = '0;
				trl_d = 3'd0;
			end else begin
				acc_d = {sum[ACC_W-7:0], 6'd0};
			end
		end
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= '0;
			trl_q <= '0;
		end else if (in_acc) begin
			acc_q <= acc_d;
			rem_q <= rem_d;
			trl_q <= trl_d;
		end
	end

	// Result register: load on a finished item, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= res_d;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && res_d) begin
			cp_q <= cp_d;
		end
	end

`ifndef SYNTH
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'd5)
		else $error("remaining count out of range");

	a_trl_cover: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != 3'd0 |-> trl_q >= rem_q)
		else $error("sequence length below remaining count");

	a_cp_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({11'd0, code_point} <= CP_MAX_LEGAL) &&
			!({11'd0, code_point} >= CP_SURR_FIRST && {11'd0, code_point} <= CP_SURR_LAST))
		else $error("illegal code point emitted");

	a_ascii_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && rem_q == 3'd0 && byte_in < 8'hC0 |=>
			out_valid && code_point == {13'd0, $past(byte_in)})
		else $error("single byte item not passed through");
`endif

endmodule

`default_nettype wire

/* sim/utf8_stream_decoder_check.sv */
module utf8_stream_decoder_check
	import usd_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_stall,
	input  wire  [BYTE_W-1:0]   byte_in,
	input  wire                 out_valid,
	input  wire                 out_stall,
	input  wire  [CP_W-1:0]     code_point,
	output int                  fails,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_MAX = 10;

	// Decoder state mirrored on the testbench side
	acc_t       sum_acc;
	trail_cnt_t trail_left;
	trail_cnt_t trail_total;

	cp_t        cp_q [$];
	cp_t        cp_want;
	int         reported;

	// Number of trailing bytes announced by a lead byte
	function automatic trail_cnt_t lead_trailers(input logic [BYTE_W-1:0] b);
		if (b < 8'hC0) return 3'd0;
		if (b < 8'hE0) return 3'd1;
		if (b < 8'hF0) return 3'd2;
		if (b < 8'hF8) return 3'd3;
		if (b < 8'hFC) return 3'd4;
		return 3'd5;
	endfunction

	// Bias that the summed lead and trailing bytes carry
	function automatic acc_t seq_bias(input trail_cnt_t n);
		acc_t bias;
		bias = '0;
		if (n == 3'd1) bias = OFFSET_1;
		if (n == 3'd2) bias = OFFSET_2;
		if (n == 3'd3) bias = OFFSET_3;
		if (n == 3'd4) bias = OFFSET_4;
		if (n == 3'd5) bias = OFFSET_5;
		return bias;
	endfunction

	// Strip the bias, then substitute the replacement for illegal values
	function automatic cp_t settle(input acc_t sum, input trail_cnt_t n);
		acc_t v;
		v = sum - seq_bias(n);
		if (v > CP_MAX_LEGAL) v = CP_REPLACE;
		if (v >= CP_SURR_FIRST && v <= CP_SURR_LAST) v = CP_REPLACE;
		return v[CP_W-1:0];
	endfunction

	// Advance the mirrored state by one byte, queue a code point on completion
	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		if (trail_left == 3'd0) begin
			if (lead_trailers(b) == 3'd0) begin
				cp_q.push_back(settle({24'h0, b}, 3'd0));
				sum_acc = '0;
			end else begin
				sum_acc     = {24'h0, b} << 6;
				trail_left  = lead_trailers(b);
				trail_total = trail_left;
			end
		end else begin
			sum_acc    = sum_acc + {24'h0, b};
			trail_left = trail_left - 3'd1;
			if (trail_left == 3'd0) begin
				cp_q.push_back(settle(sum_acc, trail_total));
				sum_acc     = '0;
				trail_total = 3'd0;
			end else begin
				sum_acc = sum_acc << 6;
			end
		end
	endtask

	// Compare delivered items first, then predict from the accepted byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_acc     = '0;
			trail_left  = 3'd0;
			trail_total = 3'd0;
			cp_q.delete();
			fails       = 0;
			reported    = 0;
			pending    <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cp_q.size() == 0) begin
					if (reported < REPORT_MAX) begin
						$display("unexpected code point %h", code_point);
					end
					reported++;
					fails++;
				end else begin
					cp_want = cp_q.pop_front();
					if (code_point !== cp_want) begin
						if (reported < REPORT_MAX) begin
							$display("code point mismatch: expected %h got %h",
								cp_want, code_point);
						end
						reported++;
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(byte_in);
			end
			pending <= cp_q.size();
		end
	end

endmodule

/* sim/utf8_stream_decoder_test.sv */
module utf8_stream_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import usd_pkg::*;

	localparam int ITEM_TARGET = 1500;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 8;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] byte_in;
	logic              out_valid;
	logic              out_stall;
	logic [CP_W-1:0]   code_point;

	int                fails;
	int                pending;
	int                cycles = 0;
	int                calm_left = 0;
	int                bytes_sent = 0;
	logic [7:0]        directed_q [$];

	utf8_stream_decoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_in    (byte_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point)
	);

	utf8_stream_decoder_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_in    (byte_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.fails      (fails),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Sender gap: mostly none or short, a few long, with calm stretches
	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm_left = $urandom_range(30, 80);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one byte after an optional gap, hold it until taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in  <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// Hold off the sender until every predicted code point has arrived
	task automatic drain_wait();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Trailing byte, mostly well formed, sometimes arbitrary
	function automatic logic [7:0] trail_byte();
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	// One sequence of random length class, or a lone noise byte
	task automatic send_sequence();
		int r;
		int n;
		logic [7:0] lead;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			send_byte(8'($urandom_range(0, 255)));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				n = 0;
				lead = 8'($urandom_range(8'h00, 8'h7F));
			end else if (r < 50) begin
				n = 1;
				lead = 8'($urandom_range(8'hC0, 8'hDF));
			end else if (r < 70) begin
				n = 2;
				lead = 8'($urandom_range(8'hE0, 8'hEF));
			end else if (r < 85) begin
				n = 3;
				lead = 8'($urandom_range(8'hF0, 8'hF7));
			end else if (r < 92) begin
				n = 4;
				lead = 8'($urandom_range(8'hF8, 8'hFB));
			end else begin
				n = 5;
				lead = 8'($urandom_range(8'hFC, 8'hFF));
			end
			send_byte(lead);
			repeat (n) send_byte(trail_byte());
		end
	endtask

	// Receiver stall pattern: short stalls, a few long, calm stretches
	initial begin
		int hold;
		int free;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
				: $urandom_range(1, 3);
			out_stall <= 1'b1;
			repeat (hold) @(posedge clk);
			out_stall <= 1'b0;
			free = ($urandom_range(0, 24) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 6);
			repeat (free) @(posedge clk);
		end
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		byte_in  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, lone continuation, surrogate, range edge,
		// long sequences, 0xFF as a lead, and an unchecked trailing byte
		directed_q = '{8'h00, 8'hBF,
			8'hC0, 8'h80,
			8'hED, 8'hA0, 8'h80,
			8'hF4, 8'h8F, 8'hBF, 8'hBF,
			8'hF4, 8'h90, 8'h80, 8'h80,
			8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hC2, 8'h41};
		foreach (directed_q[i]) send_byte(directed_q[i]);

		// Random sequences, with one full drain midway
		while (bytes_sent < ITEM_TARGET / 2) send_sequence();
		drain_wait();
		while (bytes_sent < ITEM_TARGET) send_sequence();

		drain_wait();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
